FILE: rtl/core/ole_pkg.sv
// ---------------------------------------------------------------------------
// Ordered list engine package
// Operation and status codes, controller states and the command and status
// words exchanged between the controller and the datapath.
// ---------------------------------------------------------------------------
package ole_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_RM_HEAD  = 3'd3;
  localparam logic [2:0] OP_RM_TAIL  = 3'd4;
  localparam logic [2:0] OP_RM_VALUE = 3'd5;
  localparam logic [2:0] OP_RM_POS   = 3'd6;
  localparam logic [2:0] OP_SEARCH   = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHUP_PRIME,
    S_SHUP,
    S_WRITE,
    S_READ,
    S_RM_GRAB,
    S_RM_SHIFT,
    S_SR_CMP
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_LAST,
    IDX_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    AT_ZERO,
    AT_COUNT,
    AT_POS
  } at_sel_t;

  typedef enum logic [2:0] {
    RA_IDX,
    RA_DEC,
    RA_DEC2,
    RA_INC,
    RA_INC2
  } ra_sel_t;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_RDATA,
    RV_HOLD
  } rv_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic       load;
    idx_op_t    idx_op;
    logic       at_ld;
    at_sel_t    at_sel;
    logic       rd;
    ra_sel_t    ra_sel;
    logic       wr;
    logic       wr_value;
    logic       grab;
    logic       finish;
    logic [2:0] status;
    logic       use_found;
    rv_sel_t    rv_sel;
    cnt_op_t    cnt_op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       cnt_zero;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       idx_eq_at;
    logic       idx_eq_at1;
    logic       inc1_lt_cnt;
    logic       inc2_lt_cnt;
    logic       match;
  } stat_t;

endpackage

FILE: rtl/core/ole_ctrl.sv
// ---------------------------------------------------------------------------
// Ordered list engine controller
// Decodes each request and sequences the memory walks that search the list
// and open or close a gap in it, one entry per cycle.
// ---------------------------------------------------------------------------
module ole_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ole_pkg::stat_t stat,
  output ole_pkg::cmd_t  cmd
);

  ole_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ole_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.idx_op    = ole_pkg::IDX_HOLD;
    cmd.at_ld     = 1'b0;
    cmd.at_sel    = ole_pkg::AT_ZERO;
    cmd.rd        = 1'b0;
    cmd.ra_sel    = ole_pkg::RA_IDX;
    cmd.wr        = 1'b0;
    cmd.wr_value  = 1'b0;
    cmd.grab      = 1'b0;
    cmd.finish    = 1'b0;
    cmd.status    = ole_pkg::ST_OK;
    cmd.use_found = 1'b0;
    cmd.rv_sel    = ole_pkg::RV_ZERO;
    cmd.cnt_op    = ole_pkg::CNT_HOLD;
    case (state)
      ole_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ole_pkg::S_DECODE;
        end
      end
      ole_pkg::S_DECODE: begin
        if (stat.op inside {ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL,
                            ole_pkg::OP_INS_POS}) begin
          if (stat.full) begin
            cmd.finish = 1'b1;
            cmd.status = ole_pkg::ST_FULL;
            state_next = ole_pkg::S_IDLE;
          end else if (stat.op == ole_pkg::OP_INS_POS && stat.pos_gt_cnt) begin
            cmd.finish = 1'b1;
            cmd.status = ole_pkg::ST_BADPOS;
            state_next = ole_pkg::S_IDLE;
          end else begin
            cmd.idx_op = ole_pkg::IDX_COUNT;
            cmd.at_ld  = 1'b1;
            if (stat.op == ole_pkg::OP_INS_HEAD) begin
              cmd.at_sel = ole_pkg::AT_ZERO;
            end else if (stat.op == ole_pkg::OP_INS_TAIL) begin
              cmd.at_sel = ole_pkg::AT_COUNT;
            end else begin
              cmd.at_sel = ole_pkg::AT_POS;
            end
            state_next = ole_pkg::S_SHUP_PRIME;
          end
        end else if (stat.op == ole_pkg::OP_SEARCH) begin
          if (stat.cnt_zero) begin
            cmd.finish = 1'b1;
            cmd.status = ole_pkg::ST_NOTFOUND;
            state_next = ole_pkg::S_IDLE;
          end else begin
            cmd.idx_op = ole_pkg::IDX_ZERO;
            state_next = ole_pkg::S_READ;
          end
        end else if (stat.cnt_zero) begin
          cmd.finish = 1'b1;
          cmd.status = ole_pkg::ST_EMPTY;
          state_next = ole_pkg::S_IDLE;
        end else begin
          case (stat.op)
            ole_pkg::OP_RM_HEAD: begin
              cmd.idx_op = ole_pkg::IDX_ZERO;
              state_next = ole_pkg::S_READ;
            end
            ole_pkg::OP_RM_TAIL: begin
              cmd.idx_op = ole_pkg::IDX_LAST;
              state_next = ole_pkg::S_READ;
            end
            ole_pkg::OP_RM_VALUE: begin
              cmd.idx_op = ole_pkg::IDX_ZERO;
              state_next = ole_pkg::S_READ;
            end
            default: begin
              if (stat.pos_ge_cnt) begin
                cmd.finish = 1'b1;
                cmd.status = ole_pkg::ST_BADPOS;
                state_next = ole_pkg::S_IDLE;
              end else begin
                cmd.idx_op = ole_pkg::IDX_POS;
                state_next = ole_pkg::S_READ;
              end
            end
          endcase
        end
      end
      ole_pkg::S_SHUP_PRIME: begin
        if (stat.idx_eq_at) begin
          state_next = ole_pkg::S_WRITE;
        end else begin
          cmd.rd     = 1'b1;
          cmd.ra_sel = ole_pkg::RA_DEC;
          state_next = ole_pkg::S_SHUP;
        end
      end
      ole_pkg::S_SHUP: begin
        cmd.wr     = 1'b1;
        cmd.idx_op = ole_pkg::IDX_DEC;
        if (stat.idx_eq_at1) begin
          state_next = ole_pkg::S_WRITE;
        end else begin
          cmd.rd     = 1'b1;
          cmd.ra_sel = ole_pkg::RA_DEC2;
        end
      end
      ole_pkg::S_WRITE: begin
        cmd.wr       = 1'b1;
        cmd.wr_value = 1'b1;
        cmd.finish   = 1'b1;
        cmd.cnt_op   = ole_pkg::CNT_INC;
        state_next   = ole_pkg::S_IDLE;
      end
      ole_pkg::S_READ: begin
        cmd.rd = 1'b1;
        if (stat.op == ole_pkg::OP_SEARCH || stat.op == ole_pkg::OP_RM_VALUE) begin
          state_next = ole_pkg::S_SR_CMP;
        end else begin
          state_next = ole_pkg::S_RM_GRAB;
        end
      end
      ole_pkg::S_RM_GRAB: begin
        cmd.grab = 1'b1;
        if (stat.inc1_lt_cnt) begin
          cmd.rd     = 1'b1;
          cmd.ra_sel = ole_pkg::RA_INC;
          state_next = ole_pkg::S_RM_SHIFT;
        end else begin
          cmd.finish = 1'b1;
          cmd.rv_sel = ole_pkg::RV_RDATA;
          cmd.cnt_op = ole_pkg::CNT_DEC;
          state_next = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_RM_SHIFT: begin
        cmd.wr     = 1'b1;
        cmd.idx_op = ole_pkg::IDX_INC;
        if (stat.inc2_lt_cnt) begin
          cmd.rd     = 1'b1;
          cmd.ra_sel = ole_pkg::RA_INC2;
        end else begin
          cmd.finish = 1'b1;
          cmd.rv_sel = ole_pkg::RV_HOLD;
          cmd.cnt_op = ole_pkg::CNT_DEC;
          state_next = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_SR_CMP: begin
        if (stat.match) begin
          if (stat.op == ole_pkg::OP_SEARCH) begin
            cmd.finish    = 1'b1;
            cmd.use_found = 1'b1;
            state_next    = ole_pkg::S_IDLE;
          end else begin
            cmd.grab = 1'b1;
            if (stat.inc1_lt_cnt) begin
              cmd.rd     = 1'b1;
              cmd.ra_sel = ole_pkg::RA_INC;
              state_next = ole_pkg::S_RM_SHIFT;
            end else begin
              cmd.finish = 1'b1;
              cmd.rv_sel = ole_pkg::RV_RDATA;
              cmd.cnt_op = ole_pkg::CNT_DEC;
              state_next = ole_pkg::S_IDLE;
            end
          end
        end else if (stat.inc1_lt_cnt) begin
          cmd.rd     = 1'b1;
          cmd.ra_sel = ole_pkg::RA_INC;
          cmd.idx_op = ole_pkg::IDX_INC;
        end else begin
          cmd.finish = 1'b1;
          cmd.status = ole_pkg::ST_NOTFOUND;
          state_next = ole_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ole_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/ole_dp.sv
// ---------------------------------------------------------------------------
// Ordered list engine datapath
// Entry memory, entry count, walk index and result registers, with the
// compares that the controller needs.
// ---------------------------------------------------------------------------
module ole_dp #(
  parameter int DEPTH = ole_pkg::DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ole_pkg::cmd_t        cmd,
  output ole_pkg::stat_t       stat,
  input  logic [2:0]           op,
  input  logic signed [31:0]   value,
  input  logic [CW-1:0]        position,
  output logic                 done,
  output logic [2:0]           status,
  output logic [CW-1:0]        found_position,
  output logic signed [31:0]   removed_value,
  output logic [CW-1:0]        count
);

  localparam int AW = $clog2(DEPTH);

  logic signed [31:0] mem [DEPTH];
  logic [2:0]         op_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      pos_q;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_next;
  logic [CW-1:0]      at;
  logic [CW-1:0]      ra;
  logic signed [31:0] rdata;
  logic signed [31:0] hold;
  logic signed [31:0] wd;
  logic [CW:0]        idx_w;
  logic [CW:0]        cnt_w;

  assign idx_w = {1'b0, idx};
  assign cnt_w = {1'b0, cnt};

  assign stat.op          = op_q;
  assign stat.full        = (cnt == CW'(DEPTH));
  assign stat.cnt_zero    = (cnt == '0);
  assign stat.pos_gt_cnt  = (pos_q > cnt);
  assign stat.pos_ge_cnt  = (pos_q >= cnt);
  assign stat.idx_eq_at   = (idx == at);
  assign stat.idx_eq_at1  = (idx_w == ({1'b0, at} + (CW+1)'(1)));
  assign stat.inc1_lt_cnt = ((idx_w + (CW+1)'(1)) < cnt_w);
  assign stat.inc2_lt_cnt = ((idx_w + (CW+1)'(2)) < cnt_w);
  assign stat.match       = (rdata == value_q);

  always_comb begin
    case (cmd.ra_sel)
      ole_pkg::RA_DEC:  ra = idx - CW'(1);
      ole_pkg::RA_DEC2: ra = idx - CW'(2);
      ole_pkg::RA_INC:  ra = idx + CW'(1);
      ole_pkg::RA_INC2: ra = idx + CW'(2);
      default:          ra = idx;
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      ole_pkg::IDX_ZERO:  idx_next = '0;
      ole_pkg::IDX_COUNT: idx_next = cnt;
      ole_pkg::IDX_LAST:  idx_next = cnt - CW'(1);
      ole_pkg::IDX_POS:   idx_next = pos_q;
      ole_pkg::IDX_INC:   idx_next = idx + CW'(1);
      ole_pkg::IDX_DEC:   idx_next = idx - CW'(1);
      default:            idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      ole_pkg::CNT_INC: cnt_next = cnt + CW'(1);
      ole_pkg::CNT_DEC: cnt_next = cnt - CW'(1);
      default:          cnt_next = cnt;
    endcase
  end

  assign wd = cmd.wr_value ? value_q : rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[idx[AW-1:0]] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      value_q <= value;
      pos_q   <= position;
    end
    idx <= idx_next;
    if (cmd.at_ld) begin
      case (cmd.at_sel)
        ole_pkg::AT_COUNT: at <= cnt;
        ole_pkg::AT_POS:   at <= pos_q;
        default:           at <= '0;
      endcase
    end
    if (cmd.grab) begin
      hold <= rdata;
    end
    if (cmd.finish) begin
      status         <= cmd.status;
      found_position <= cmd.use_found ? (idx + CW'(1)) : '0;
      count          <= cnt_next;
      case (cmd.rv_sel)
        ole_pkg::RV_RDATA: removed_value <= rdata;
        ole_pkg::RV_HOLD:  removed_value <= hold;
        default:           removed_value <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        cnt <= cnt_next;
      end
    end
  end

  a_no_grow_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && cmd.cnt_op == ole_pkg::CNT_INC) |-> !stat.full)
    else $error("Count raised on a full list.");

  a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && cmd.cnt_op == ole_pkg::CNT_DEC) |-> !stat.cnt_zero)
    else $error("Count lowered on an empty list.");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (idx < CW'(DEPTH)))
    else $error("Memory write beyond the list depth.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe held for two cycles.");

endmodule

FILE: rtl/core/ordered_list_engine.sv
// ---------------------------------------------------------------------------
// Ordered list engine
// Ordered list of up to DEPTH signed 32-bit values with insert, remove and
// search requests, one request at a time.
// ---------------------------------------------------------------------------
// A request word (op, value, position) is taken at a rising edge with start
// high and busy low. busy stays high until the result is issued. Each result
// word (status, found_position, removed_value, count) is on its ports for
// one cycle with done high; the receiver cannot stall it, and busy is
// already low in that cycle, so a new request may be taken there.
// The time from the accepting edge to the cycle with done high depends on
// the entry count n and the target position p, and is set by the entry
// memory, which moves one entry per cycle:
//   rejected request (full, empty, bad position, search on empty): decode only
//   insert at p: shifts the n - p entries from p upward, then writes
//   remove at p: shifts the n - p - 1 entries above p down
//   search or remove by value: walks to the match at index k, plus the
//   shift as above on a removal; walks all n entries when nothing matches
// One request is in flight at a time; the next is taken once busy is low.
// Synchronous reset empties the list at once; entry contents are left as
// they are and are never read before they are written.
// ---------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           op,
  input  logic signed [31:0]   value,
  input  logic [CW-1:0]        position,
  output logic                 done,
  output logic [2:0]           status,
  output logic [CW-1:0]        found_position,
  output logic signed [31:0]   removed_value,
  output logic [CW-1:0]        count
);

  ole_pkg::cmd_t  cmd;
  ole_pkg::stat_t stat;

  ole_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .value          (value),
    .position       (position),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .removed_value  (removed_value),
    .count          (count)
  );

endmodule
